[design/sct_pkg.sv]
// Shared types and fixed-point constants for the Taylor-series sine/cosine block.
// No dependencies; every other file of the block imports this package.
package sct_pkg;

  // Default values of the top-level parameters
  localparam int TERMS_DEF       = 16;
  localparam int ANGLE_FRAC_DEF  = 24;
  localparam int RESULT_FRAC_DEF = 30;

  // Port widths
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;

  // Working format: Q50 unsigned magnitudes, independent of the parameters
  localparam int WORK_FRAC = 50;
  localparam int U_W       = 53;  // reduced angle, below 2*pi
  localparam int X2_W      = 56;  // square of the reduced angle
  localparam int T_W       = 57;  // one series term
  localparam int P_W       = 62;  // term times x squared, before the divide
  localparam int RECIP_W   = 63;  // reciprocal of a divisor, P_W + 1 bits
  localparam int SUM_W     = 60;  // signed running sum
  localparam int REM_W     = 64;  // angle magnitude with 32 extra fraction bits

  // Two pi with 60 fraction bits
  localparam logic [REM_W-1:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  // One in the term format
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << WORK_FRAC;

  // Function select codes
  typedef enum logic {
    OP_SIN = 1'b0,
    OP_COS = 1'b1
  } sct_op_t;

  // Per-beat control carried alongside the data
  typedef struct packed {
    logic cos;  // cosine selected
    logic neg;  // input angle was negative
  } sct_tag_t;

endpackage

[design/sct_front.sv]
// Front end: angle magnitude, reduction by whole turns of two pi, and x squared.
// Depends on sct_pkg. Produces the first series term and x squared for the cell row.
module sct_front import sct_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic                    op,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                    out_valid,
  output sct_tag_t                out_tag,
  output logic [T_W-1:0]          out_t,
  output logic [X2_W-1:0]         out_x2
);

  // Quotient bits of the turn count; 2*pi > 4 bounds it
  localparam int QB  = 29 - ANGLE_FRAC_BITS;
  localparam logic [REM_W-1:0] TP = TWO_PI_Q60 >> (28 - ANGLE_FRAC_BITS);
  localparam int USH = ANGLE_FRAC_BITS + 32 - WORK_FRAC;
  localparam int UH_W = U_W - 32;
  localparam int SQ_W = 2 * U_W;

  logic [ANGLE_W-1:0] angle_u;
  logic [ANGLE_W-1:0] mag;

  logic [REM_W-1:0] rem  [QB+1];
  sct_tag_t         rtag [QB+1];
  logic             rv   [QB+1];

  logic [U_W-1:0] u;

  logic [63:0]          sq_ll;
  logic [UH_W+31:0]     sq_lh;
  logic [2*UH_W-1:0]    sq_hh;
  logic [U_W-1:0]       sq_u;
  sct_tag_t             sq_tag;
  logic                 sq_v;
  logic [SQ_W-1:0]      sq_full;

  // Magnitude of the angle; the most negative code maps to 2^31 exactly
  assign angle_u = angle;
  assign mag = angle_u[ANGLE_W-1] ? (~angle_u + 1'b1) : angle_u;

  // Valid bits of the reduction stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QB; i++) rv[i] <= 1'b0;
    end else if (en) begin
      rv[0] <= in_valid;
      for (int i = 1; i <= QB; i++) rv[i] <= rv[i-1];
    end
  end

  // Load the magnitude, then one compare-subtract of a shifted turn per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]      <= {mag, 32'b0};
      rtag[0].cos <= (op == OP_COS);
      rtag[0].neg <= angle_u[ANGLE_W-1];
      for (int i = 1; i <= QB; i++) begin
        rem[i]  <= (rem[i-1] >= (TP << (QB - i))) ? (rem[i-1] - (TP << (QB - i)))
                                                  : rem[i-1];
        rtag[i] <= rtag[i-1];
      end
    end
  end

  // Rescale the remainder to Q50
  if (USH >= 0) begin : g_shr
    assign u = U_W'(rem[QB] >> USH);
  end else begin : g_shl
    assign u = U_W'(rem[QB] << (-USH));
  end

  // Square the reduced angle: partial products, then sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sq_v      <= rv[QB];
      out_valid <= sq_v;
    end
  end

  assign sq_full = SQ_W'(sq_ll) + (SQ_W'(sq_lh) << 33) + (SQ_W'(sq_hh) << 64);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ll   <= u[31:0] * u[31:0];
      sq_lh   <= u[31:0] * u[U_W-1:32];
      sq_hh   <= u[U_W-1:32] * u[U_W-1:32];
      sq_u    <= u;
      sq_tag  <= rtag[QB];
      out_x2  <= sq_full[WORK_FRAC +: X2_W];
      out_t   <= sq_tag.cos ? T_ONE : T_W'(sq_u);
      out_tag <= sq_tag;
    end
  end

  // Remainder leaving the reduction is below one turn
  a_rem_below_turn: assert property (@(posedge clk) disable iff (rst)
    rv[QB] |-> (rem[QB] < TP))
    else $error("reduced angle not below two pi");

endmodule

[design/sct_term_cell.sv]
// One cell of the series row: next term = floor(t * x2 / 2^50 / d), and sum update.
// Depends on sct_pkg. Four stages: product parts, product, reciprocal parts, quotient.
module sct_term_cell import sct_pkg::*; #(
  parameter int K = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  sct_tag_t                in_tag,
  input  logic [T_W-1:0]          in_t,
  input  logic [X2_W-1:0]         in_x2,
  input  logic signed [SUM_W-1:0] in_sum,
  output logic                    out_valid,
  output sct_tag_t                out_tag,
  output logic [T_W-1:0]          out_t,
  output logic [X2_W-1:0]         out_x2,
  output logic signed [SUM_W-1:0] out_sum
);

  localparam int TH_W = T_W - 32;
  localparam int XH_W = X2_W - 32;
  localparam int PH_W = P_W - 32;
  localparam int RH_W = RECIP_W - 32;
  localparam int M1_W = T_W + X2_W;

  // Divisors of this term and their exact reciprocals for a P_W-bit dividend
  localparam int D_SIN = 2 * K * (2 * K + 1);
  localparam int D_COS = (2 * K - 1) * (2 * K);
  localparam int S_SIN = P_W + $clog2(D_SIN);
  localparam int S_COS = P_W + $clog2(D_COS);
  localparam int RC_W  = S_SIN + 2;
  localparam logic [RC_W-1:0] R_SIN_FULL =
    ((RC_W'(1) << S_SIN) + RC_W'(D_SIN - 1)) / RC_W'(D_SIN);
  localparam logic [RC_W-1:0] R_COS_FULL =
    ((RC_W'(1) << S_COS) + RC_W'(D_COS - 1)) / RC_W'(D_COS);
  localparam logic [RECIP_W-1:0] R_SIN = R_SIN_FULL[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] R_COS = R_COS_FULL[RECIP_W-1:0];
  localparam int M2_W = (P_W + RECIP_W > S_SIN + T_W) ? (P_W + RECIP_W) : (S_SIN + T_W);

  // The incoming term has index K-1: odd indexes subtract
  localparam bit SUB = ((K - 1) % 2) != 0;

  logic signed [SUM_W-1:0] tx;

  logic                    v1, v2, v3;
  sct_tag_t                tag1, tag2, tag3;
  logic [X2_W-1:0]         x2_1, x2_2, x2_3;
  logic signed [SUM_W-1:0] sum1, sum2, sum3;

  logic [63:0]        ll1;
  logic [XH_W+31:0]   lh1;
  logic [TH_W+31:0]   hl1;
  logic [TH_W+XH_W-1:0] hh1;
  logic [M1_W-1:0]    full1;
  logic [P_W-1:0]     p2;

  logic [RECIP_W-1:0] recip;
  logic [63:0]        ll3;
  logic [RH_W+31:0]   lh3;
  logic [PH_W+31:0]   hl3;
  logic [PH_W+RH_W-1:0] hh3;
  logic [M2_W-1:0]    full2;

  assign tx = $signed({{(SUM_W - T_W){1'b0}}, in_t});

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  assign full1 = M1_W'(ll1) + (M1_W'(lh1) << 32) + (M1_W'(hl1) << 32) + (M1_W'(hh1) << 64);
  assign recip = tag2.cos ? R_COS : R_SIN;
  assign full2 = M2_W'(ll3) + (M2_W'(lh3) << 32) + (M2_W'(hl3) << 32) + (M2_W'(hh3) << 64);

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: parts of t * x2; fold the incoming term into the sum
      ll1  <= in_t[31:0] * in_x2[31:0];
      lh1  <= in_t[31:0] * in_x2[X2_W-1:32];
      hl1  <= in_t[T_W-1:32] * in_x2[31:0];
      hh1  <= in_t[T_W-1:32] * in_x2[X2_W-1:32];
      sum1 <= SUB ? (in_sum - tx) : (in_sum + tx);
      x2_1 <= in_x2;
      tag1 <= in_tag;
      // Stage 2: drop the working fraction
      p2   <= full1[WORK_FRAC +: P_W];
      sum2 <= sum1;
      x2_2 <= x2_1;
      tag2 <= tag1;
      // Stage 3: parts of p times the divisor reciprocal
      ll3  <= p2[31:0] * recip[31:0];
      lh3  <= p2[31:0] * recip[RECIP_W-1:32];
      hl3  <= p2[P_W-1:32] * recip[31:0];
      hh3  <= p2[P_W-1:32] * recip[RECIP_W-1:32];
      sum3 <= sum2;
      x2_3 <= x2_2;
      tag3 <= tag2;
      // Stage 4: quotient is the new term
      out_t   <= tag3.cos ? full2[S_COS +: T_W] : full2[S_SIN +: T_W];
      out_sum <= sum3;
      out_x2  <= x2_3;
      out_tag <= tag3;
    end
  end

endmodule

[design/sct_finish.sv]
// Back end: add the last term, round the sum to the result format, saturate, sign.
// Depends on sct_pkg. Three stages; the result leaves combinationally from the last.
module sct_finish import sct_pkg::*; #(
  parameter int TERMS            = TERMS_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  sct_tag_t                  in_tag,
  input  logic [T_W-1:0]            in_t,
  input  logic signed [SUM_W-1:0]   in_sum,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_value
);

  localparam bit SUB   = ((TERMS - 1) % 2) != 0;
  localparam int DROP  = WORK_FRAC - RESULT_FRAC_BITS;
  localparam int RND_W = SUM_W + 1;
  localparam int RN_W  = RND_W - DROP;
  localparam int RS_W  = RESULT_FRAC_BITS + 1;
  localparam logic [RND_W-1:0] HALF  = RND_W'(1) << (DROP - 1);
  localparam logic [RN_W-1:0]  ONE_R = RN_W'(1) << RESULT_FRAC_BITS;

  logic signed [SUM_W-1:0] tx;
  logic                    v0, v1;
  sct_tag_t                tag0;
  logic signed [SUM_W-1:0] fsum;
  logic                    rneg1, rneg2;
  logic [SUM_W-1:0]        smag;
  logic [RN_W-1:0]         rr;
  logic [RND_W-1:0]        rsum;
  logic [RS_W-1:0]         rsat;
  logic [VALUE_W-1:0]      mag_v;

  assign tx   = $signed({{(SUM_W - T_W){1'b0}}, in_t});
  assign rsum = RND_W'(smag) + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Add the last term
      fsum  <= SUB ? (in_sum - tx) : (in_sum + tx);
      tag0  <= in_tag;
      // Split into magnitude and sign; sine of a negative angle flips
      smag  <= fsum[SUM_W-1] ? (~fsum + 1'b1) : fsum;
      rneg1 <= fsum[SUM_W-1] ^ (!tag0.cos && tag0.neg);
      // Round half away from zero
      rr    <= rsum[DROP +: RN_W];
      rneg2 <= rneg1;
    end
  end

  // Saturate to one and apply the sign; a zero magnitude stays zero
  assign rsat      = (rr > ONE_R) ? ONE_R[RS_W-1:0] : rr[RS_W-1:0];
  assign mag_v     = VALUE_W'(rsat);
  assign out_value = rneg2 ? (~mag_v + 1'b1) : mag_v;

endmodule

[design/sin_cos_taylor_series.sv]
// Taylor-series sine/cosine. Takes one angle beat per clock while arg_ready is high and
// returns one value beat per angle, in order. The pipe holds one input stage, one
// compare-subtract stage per quotient bit of the turn count, two squaring stages, four
// stages in each of the TERMS-1 term cells (two split multiplies each), three rounding
// stages and the output register. The whole row advances together; a one-beat skid behind
// the output register keeps arg_ready high while a result waits, and arg_ready drops only
// while the skid holds a beat. Reset clears only the valid bits.
module sin_cos_taylor_series import sct_pkg::*; #(
  parameter int TERMS            = TERMS_DEF,
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      arg_valid,
  output logic                      arg_ready,
  input  logic                      op,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic signed [VALUE_W-1:0] value
);

  localparam logic signed [VALUE_W-1:0] ONE_V = VALUE_W'(1) << RESULT_FRAC_BITS;

  logic en;

  logic                    c_valid [TERMS];
  sct_tag_t                c_tag   [TERMS];
  logic [T_W-1:0]          c_t     [TERMS];
  logic [X2_W-1:0]         c_x2    [TERMS];
  logic signed [SUM_W-1:0] c_sum   [TERMS];

  logic                      fin_valid;
  logic signed [VALUE_W-1:0] fin_value;
  logic                      res_fire;

  logic                      skid_valid;
  logic signed [VALUE_W-1:0] skid_value;

  // Whole pipe advances unless the skid is holding a beat
  assign en        = !skid_valid;
  assign arg_ready = en;

  sct_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (arg_valid),
    .op       (op),
    .angle    (angle),
    .out_valid(c_valid[0]),
    .out_tag  (c_tag[0]),
    .out_t    (c_t[0]),
    .out_x2   (c_x2[0])
  );

  assign c_sum[0] = '0;

  // Row of term cells, one per series term after the first
  for (genvar k = 1; k < TERMS; k++) begin : g_cell
    sct_term_cell #(
      .K(k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (c_valid[k-1]),
      .in_tag   (c_tag[k-1]),
      .in_t     (c_t[k-1]),
      .in_x2    (c_x2[k-1]),
      .in_sum   (c_sum[k-1]),
      .out_valid(c_valid[k]),
      .out_tag  (c_tag[k]),
      .out_t    (c_t[k]),
      .out_x2   (c_x2[k]),
      .out_sum  (c_sum[k])
    );
  end

  sct_finish #(
    .TERMS           (TERMS),
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_finish (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid[TERMS-1]),
    .in_tag   (c_tag[TERMS-1]),
    .in_t     (c_t[TERMS-1]),
    .in_sum   (c_sum[TERMS-1]),
    .out_valid(fin_valid),
    .out_value(fin_value)
  );

  assign res_fire = en && fin_valid;

  // Output register with a one-beat skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      if (skid_valid) begin
        value <= skid_value;
      end else if (res_fire) begin
        value <= fin_value;
      end
    end else if (res_fire) begin
      skid_value <= fin_value;
    end
  end

  // Skid holds a beat only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds a beat while the output is empty");

  // Skid fills only when the output beat was stalled
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(res_valid && !res_ready))
    else $error("skid filled without a stalled output beat");

  // Result stays within plus or minus one
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (value <= ONE_V && value >= -ONE_V))
    else $error("result outside plus or minus one");

endmodule

[tb/sv/tb_top.sv]
// Testbench for sin_cos_taylor_series: drives angle beats under several idle/stall mixes
// and checks every value beat against an in-bench fixed-point Taylor predictor.
// Depends on sct_pkg and the sin_cos_taylor_series RTL only.
`timescale 1ns / 1ps

module tb_top import sct_pkg::*; ();

  // Pipeline depth at default parameters, plus margins for the end of the run
  localparam int LATENCY     = (29 - ANGLE_FRAC_DEF) + 4 * TERMS_DEF + 3;
  localparam int DRAIN_LIMIT = 20000;

  // Fixed-point helpers for the predictor
  localparam int SHIFT_TO_WORK = ANGLE_FRAC_DEF + 32 - WORK_FRAC;
  localparam int DROP_BITS     = WORK_FRAC - RESULT_FRAC_DEF;
  localparam logic [63:0] UNIT_RESULT = 64'd1 << RESULT_FRAC_DEF;

  // Angles in Q24 used by the directed, principal-turn and near-quadrant stimulus
  localparam int HALF_PI_Q24 = 26353589;
  localparam int PI_Q24      = 52707179;
  localparam int TWO_PI_Q24  = 105414357;

  typedef struct {
    logic        op;
    logic [31:0] angle;
    logic [31:0] value;
  } sincos_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic arg_valid = 1'b0;
  logic arg_ready;
  logic op = 1'b0;
  logic signed [ANGLE_W-1:0] angle = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic signed [VALUE_W-1:0] value;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  sincos_beat_t pending_values[$];
  sincos_beat_t oldest_value;

  sin_cos_taylor_series u_top (
    .clk       (clk),
    .rst       (rst),
    .arg_valid (arg_valid),
    .arg_ready (arg_ready),
    .op        (op),
    .angle     (angle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .value     (value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Expected sin/cos value of one angle beat, in the output format
  function automatic logic [31:0] sincos_value(input logic f_op, input logic [31:0] raw);
    logic        cosine;
    logic        neg;
    logic        sneg;
    logic [63:0] mag;
    logic [63:0] turn;
    logic [63:0] rem;
    logic [63:0] u;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] smag;
    logic [63:0] r;
    logic [127:0] prod;
    logic signed [63:0] sum;
    int k;
    cosine = (sct_op_t'(f_op) == OP_COS);
    neg = raw[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    // Reduce by whole turns, truncating toward zero
    turn = TWO_PI_Q60 >> (28 - ANGLE_FRAC_DEF);
    rem = (mag << 32) % turn;
    u = (SHIFT_TO_WORK >= 0) ? (rem >> SHIFT_TO_WORK) : (rem << (-SHIFT_TO_WORK));
    prod = {64'd0, u} * {64'd0, u};
    x2 = prod[WORK_FRAC +: 64];
    // Sum alternating terms, each from the previous one
    t = cosine ? (64'd1 << WORK_FRAC) : u;
    sum = signed'(t);
    for (k = 1; k < TERMS_DEF; k++) begin
      d = cosine ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
      prod = {64'd0, t} * {64'd0, x2};
      t = prod[WORK_FRAC +: 64] / d;
      if (k % 2 == 1) sum = sum - signed'(t);
      else sum = sum + signed'(t);
    end
    // Round magnitude half away from zero, saturate, then apply the sign
    sneg = (sum < 0);
    smag = sneg ? 64'(-sum) : 64'(sum);
    r = (smag + (64'd1 << (DROP_BITS - 1))) >> DROP_BITS;
    if (r > UNIT_RESULT) r = UNIT_RESULT;
    if (!cosine && neg) sneg = !sneg;
    return (sneg && r != 0) ? 32'(-r) : r[31:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one angle beat; called and returns at a rising edge
  task automatic send_angle(input logic f_op, input logic [31:0] f_angle);
    int gap;
    sincos_beat_t beat;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      arg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    arg_valid <= 1'b1;
    op        <= f_op;
    angle     <= f_angle;
    do @(negedge clk); while (!arg_ready);
    @(posedge clk);
    beat.op    = f_op;
    beat.angle = f_angle;
    beat.value = sincos_value(f_op, f_angle);
    pending_values = {pending_values, beat};
  endtask

  // Randomize receiver backpressure every cycle
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each value beat against the oldest pending expectation
  always @(negedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("unexpected value beat %h", value));
      end else begin
        oldest_value = pending_values.pop_front();
        if (value !== oldest_value.value)
          report_mismatch($sformatf("op %0d angle %h: value %h, expected %h",
                                    oldest_value.op, oldest_value.angle, value,
                                    oldest_value.value));
      end
    end
  end

  // Zero, smallest steps, range extremes and multiples of pi/2, both functions
  task automatic test_corner_angles();
    logic [31:0] corners[12];
    corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'(HALF_PI_Q24), 32'(-HALF_PI_Q24), 32'(PI_Q24), 32'(-PI_Q24),
                32'(TWO_PI_Q24), 32'(TWO_PI_Q24 + 1), 32'(-TWO_PI_Q24 - 1)};
    foreach (corners[i]) begin
      send_angle(OP_SIN, corners[i]);
      send_angle(OP_COS, corners[i]);
    end
  endtask

  // Any 32-bit angle, many turns deep
  task automatic test_full_range(input int count);
    repeat (count) send_angle(1'($urandom_range(1)), $urandom());
  endtask

  // Angles within about one turn either side of zero
  task automatic test_principal_turn(input int count);
    repeat (count)
      send_angle(1'($urandom_range(1)),
                 32'($urandom_range(2 * TWO_PI_Q24) - TWO_PI_Q24));
  endtask

  // Angles within a few steps of a multiple of pi/2, where saturation and zeros occur
  task automatic test_quadrant_edges(input int count);
    int quadrant;
    repeat (count) begin
      quadrant = $urandom_range(8);
      send_angle(1'($urandom_range(1)),
                 32'((quadrant - 4) * HALF_PI_Q24 + $urandom_range(64) - 32));
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Back-to-back beats
    set_idling(0, 0);
    test_corner_angles();
    test_full_range(150);
    test_principal_turn(150);
    test_quadrant_edges(50);

    // Sender idles
    set_idling(51, 0);
    test_full_range(100);
    test_principal_turn(100);
    test_quadrant_edges(50);

    // Receiver stalls
    set_idling(0, 51);
    test_full_range(100);
    test_principal_turn(100);
    test_quadrant_edges(50);

    // Light idling on both sides
    set_idling(7, 7);
    test_full_range(100);
    test_principal_turn(100);
    test_quadrant_edges(50);

    arg_valid <= 1'b0;

    // Drain the pipeline, then watch for stray beats
    waited = 0;
    while (pending_values.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (pending_values.size() != 0)
      report_mismatch($sformatf("%0d expected values never arrived", pending_values.size()));

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
